@@ rtl/core/window_median_filter_top_assert.svh @@
// ----------------------------------------------------------------------------
// Window median filter assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef WINDOW_MEDIAN_FILTER_TOP_ASSERT_SVH
`define WINDOW_MEDIAN_FILTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define WMF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("window median filter assertion failed");

`define WMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("window median filter assertion failed");

`else

`define WMF_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define WMF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/wmf_pkg.sv @@
// ----------------------------------------------------------------------------
// Window median filter package
// Window size, derived widths and the transfer payload types.
// ----------------------------------------------------------------------------
package wmf_pkg;

    localparam int WINDOW         = 10;
    localparam int SAMPLE_W       = 16;
    localparam int SAMPLE_COUNT_W = 4;
    localparam int CNT_W          = $clog2(WINDOW + 1);
    localparam int IDX_W          = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] median;
        logic [SAMPLE_COUNT_W-1:0]  sample_count;
    } t_out_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       gt;
    } t_link;

    typedef struct packed {
        logic             insert;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] lo_idx;
        logic [IDX_W-1:0] hi_idx;
    } t_cell_ctrl;

endpackage

@@ rtl/core/window_median_filter_top.sv @@
// ----------------------------------------------------------------------------
// Window median filter
// Sorted insertion chain of WINDOW cells with a median output stage.
//
//   Channel   Handshake            Payload
//   input     i_valid / o_stall    i_item  (sample, last)
//   output    o_valid / i_stall    o_item  (median, sample_count)
//
// The chain inserts one sample per cycle while o_stall is low. A sample with
// last is inserted first; the two middle cells are then averaged into the
// output register, which may wait while that register still holds an earlier
// result that is stalled.
// Samples beyond WINDOW in one window are dropped but still close it on last.
// Reset clears the fill count and the output valid; cell contents are not reset.
// ----------------------------------------------------------------------------
`include "window_median_filter_top_assert.svh"

module window_median_filter_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  wmf_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output wmf_pkg::t_out_item  o_item
);

    logic [wmf_pkg::CNT_W-1:0]    r_count;
    logic [wmf_pkg::CNT_W-1:0]    n_count;
    logic                         r_calc;
    logic                         n_calc;
    logic                         accept;
    logic                         full;
    logic                         out_free;
    logic                         load;
    logic [wmf_pkg::CNT_W-1:0]    count_m1;
    wmf_pkg::t_cell_ctrl          ctrl;
    wmf_pkg::t_link               links [wmf_pkg::WINDOW+1];
    logic [wmf_pkg::SAMPLE_W-1:0] lo_vals [wmf_pkg::WINDOW];
    logic [wmf_pkg::SAMPLE_W-1:0] hi_vals [wmf_pkg::WINDOW];
    logic [wmf_pkg::SAMPLE_W-1:0] lo_sel;
    logic [wmf_pkg::SAMPLE_W-1:0] hi_sel;

    assign o_stall  = r_calc;
    assign accept   = i_valid && !r_calc;
    assign full     = r_count == wmf_pkg::CNT_W'(wmf_pkg::WINDOW);
    assign load     = r_calc && out_free;
    assign count_m1 = r_count - wmf_pkg::CNT_W'(1);

    assign ctrl.insert = accept && !full;
    assign ctrl.count  = r_count;
    assign ctrl.lo_idx = wmf_pkg::IDX_W'(count_m1 >> 1);
    assign ctrl.hi_idx = wmf_pkg::IDX_W'(r_count >> 1);

    always_comb begin
        n_count = r_count;
        n_calc  = r_calc;
        if (load) begin
            n_count = '0;
            n_calc  = 1'b0;
        end else if (accept) begin
            if (!full) begin
                n_count = r_count + wmf_pkg::CNT_W'(1);
            end
            n_calc = i_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_calc  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_calc  <= n_calc;
        end
    end

    assign links[0] = '0;

    for (genvar g = 0; g < wmf_pkg::WINDOW; g++) begin : g_cell
        wmf_cell u_cell (
            .i_clk    (i_clk),
            .i_index  (wmf_pkg::IDX_W'(g)),
            .i_ctrl   (ctrl),
            .i_sample (i_item.sample),
            .i_prev   (links[g]),
            .o_link   (links[g+1]),
            .o_lo     (lo_vals[g]),
            .o_hi     (hi_vals[g])
        );
    end

    always_comb begin
        lo_sel = '0;
        hi_sel = '0;
        for (int k = 0; k < wmf_pkg::WINDOW; k++) begin
            lo_sel = lo_sel | lo_vals[k];
            hi_sel = hi_sel | hi_vals[k];
        end
    end

    wmf_median u_median (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_lo    (lo_sel),
        .i_hi    (hi_sel),
        .i_count (r_count),
        .i_stall (i_stall),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

    `WMF_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= wmf_pkg::CNT_W'(wmf_pkg::WINDOW))
    `WMF_ASSERT_NEXT(a_last_starts_calc, i_clk, i_rst_n, accept && i_item.last, r_calc)
    `WMF_ASSERT_NEXT(a_load_restarts, i_clk, i_rst_n, load, o_valid && (r_count == '0) && !r_calc)
    `WMF_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, accept && !i_item.last && !full, r_count == $past(r_count) + wmf_pkg::CNT_W'(1))

endmodule

@@ rtl/core/wmf_cell.sv @@
// ----------------------------------------------------------------------------
// Window median filter sorting cell
// Holds one sorted entry, shifts in its lower neighbor on a smaller insert and
// offers its value when it is one of the two middle entries.
// ----------------------------------------------------------------------------
module wmf_cell (
    input  logic                               i_clk,
    input  logic [wmf_pkg::IDX_W-1:0]          i_index,
    input  wmf_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [wmf_pkg::SAMPLE_W-1:0] i_sample,
    input  wmf_pkg::t_link                     i_prev,
    output wmf_pkg::t_link                     o_link,
    output logic [wmf_pkg::SAMPLE_W-1:0]       o_lo,
    output logic [wmf_pkg::SAMPLE_W-1:0]       o_hi
);

    logic signed [wmf_pkg::SAMPLE_W-1:0] r_value;
    logic signed [wmf_pkg::SAMPLE_W-1:0] n_value;
    logic [wmf_pkg::CNT_W-1:0]           index_ext;
    logic                                occupied;
    logic                                gt;
    logic                                write;

    assign index_ext = wmf_pkg::CNT_W'(i_index);
    assign occupied  = index_ext < i_ctrl.count;
    assign gt        = occupied && (r_value > i_sample);
    assign write     = i_ctrl.insert && (gt || (index_ext == i_ctrl.count));
    assign n_value   = i_prev.gt ? i_prev.value : i_sample;

    always_ff @(posedge i_clk) begin
        if (write) begin
            r_value <= n_value;
        end
    end

    assign o_link.value = r_value;
    assign o_link.gt    = gt;
    assign o_lo = (i_index == i_ctrl.lo_idx) ? r_value : '0;
    assign o_hi = (i_index == i_ctrl.hi_idx) ? r_value : '0;

endmodule

@@ rtl/core/wmf_median.sv @@
// ----------------------------------------------------------------------------
// Window median filter output stage
// Averages the two middle entries with floor rounding and holds the result
// until the output transfer completes.
// ----------------------------------------------------------------------------
module wmf_median (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [wmf_pkg::SAMPLE_W-1:0]  i_lo,
    input  logic [wmf_pkg::SAMPLE_W-1:0]  i_hi,
    input  logic [wmf_pkg::CNT_W-1:0]     i_count,
    input  logic                          i_stall,
    output logic                          o_free,
    output logic                          o_valid,
    output wmf_pkg::t_out_item            o_item
);

    logic                                  r_valid;
    wmf_pkg::t_out_item                    r_item;
    wmf_pkg::t_out_item                    n_item;
    logic signed [wmf_pkg::SAMPLE_W:0]     sum;

    assign sum = $signed({i_lo[wmf_pkg::SAMPLE_W-1], i_lo})
               + $signed({i_hi[wmf_pkg::SAMPLE_W-1], i_hi});

    assign n_item.median       = wmf_pkg::SAMPLE_W'(sum >>> 1);
    assign n_item.sample_count = wmf_pkg::SAMPLE_COUNT_W'(i_count);

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
